// File: hdl/ctfs_pkg.sv
// ----------------------------------------------------------------------------
// Charge termination sequencer package
// Shared widths, reset values, codes and item types for the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ctfs_pkg;

    localparam int VOLT_W     = 13;
    localparam int CUR_W      = 11;
    localparam int DEC_W      = 10;
    localparam int IMEAS_W    = 15;
    localparam int BOOST_W    = 9;
    localparam int FORCE_W    = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int CMP_W      = 16;

    localparam int FULL_CHECK_TIMES_DEF = 3;
    localparam int FFC_EXIT_TIMES_DEF   = 5;
    localparam int FFC_DELAY_TICKS_DEF  = 3;

    localparam logic [VOLT_W-1:0]  TERM_VOLTAGE_RST     = 13'd4450;
    localparam logic [CUR_W-1:0]   TERM_CURRENT_RST     = 11'd160;
    localparam logic [CUR_W-1:0]   FFC_TERM_CURRENT_RST = 11'd0;
    localparam logic [FORCE_W-1:0] FORCED_ITERM_MA      = 10'd750;
    localparam logic [BOOST_W-1:0] DELAY_BOOST_MV       = 9'd40;

    localparam logic signed [CMP_W-1:0] FULL_DELTA_MV    = 16'sd20;
    localparam logic signed [CMP_W-1:0] CURRENT_FLOOR_MA = -16'sd10;
    localparam logic signed [CMP_W-1:0] DUAL_TOTAL_MA    = 16'sd300;
    localparam logic signed [CMP_W-1:0] DUAL_SINGLE_MA   = 16'sd60;

    typedef enum logic [1:0] {
        OP_TICK        = 2'd0,
        OP_STOP        = 2'd1,
        OP_CHECK_START = 2'd2,
        OP_UNUSED      = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TERM_VOLTAGE     = 3'd0,
        CFG_TERM_CURRENT     = 3'd1,
        CFG_FFC_TERM_CURRENT = 3'd2,
        CFG_FORCE_TERM_EN    = 3'd3,
        CFG_FFC_AFTER_DC     = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [VOLT_W-1:0] term_voltage_mv;
        logic [CUR_W-1:0]  term_current_ma;
        logic [CUR_W-1:0]  ffc_term_current_ma;
        logic              force_term_enable;
        logic              ffc_after_dc_done_only;
    } cfg_t;

    typedef struct packed {
        logic [1:0]                op;
        logic                      battery_present;
        logic                      charger_enabled;
        logic [VOLT_W-1:0]         bat_voltage_mv;
        logic [DEC_W-1:0]          vterm_decrease_mv;
        logic signed [IMEAS_W-1:0] charge_current_ma;
        logic signed [IMEAS_W-1:0] charge_current_avg_ma;
        logic                      aux_gauge_present;
        logic signed [IMEAS_W-1:0] main_gauge_current_ma;
        logic signed [IMEAS_W-1:0] aux_gauge_current_ma;
        logic [BOOST_W-1:0]        ffc_boost_request_mv;
        logic                      dc_charge_done;
    } in_item_t;

    typedef struct packed {
        logic [BOOST_W-1:0] voltage_boost_mv;
        logic               iterm_update_valid;
        logic [CUR_W-1:0]   iterm_update_ma;
        logic               full_detected;
        logic               force_term_valid;
        logic [FORCE_W-1:0] force_term_ma;
    } out_item_t;

endpackage

`default_nettype wire

// File: hdl/ctfs_if.sv
// ----------------------------------------------------------------------------
// Sequencer channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctfs_in_if;
    import ctfs_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [1:0]                op;
    logic                      battery_present;
    logic                      charger_enabled;
    logic [VOLT_W-1:0]         bat_voltage_mv;
    logic [DEC_W-1:0]          vterm_decrease_mv;
    logic signed [IMEAS_W-1:0] charge_current_ma;
    logic signed [IMEAS_W-1:0] charge_current_avg_ma;
    logic                      aux_gauge_present;
    logic signed [IMEAS_W-1:0] main_gauge_current_ma;
    logic signed [IMEAS_W-1:0] aux_gauge_current_ma;
    logic [BOOST_W-1:0]        ffc_boost_request_mv;
    logic                      dc_charge_done;

    modport source (
        output valid, op, battery_present, charger_enabled, bat_voltage_mv,
               vterm_decrease_mv, charge_current_ma, charge_current_avg_ma,
               aux_gauge_present, main_gauge_current_ma, aux_gauge_current_ma,
               ffc_boost_request_mv, dc_charge_done,
        input  ready
    );

    modport sink (
        input  valid, op, battery_present, charger_enabled, bat_voltage_mv,
               vterm_decrease_mv, charge_current_ma, charge_current_avg_ma,
               aux_gauge_present, main_gauge_current_ma, aux_gauge_current_ma,
               ffc_boost_request_mv, dc_charge_done,
        output ready
    );
endinterface

interface ctfs_out_if;
    import ctfs_pkg::*;

    logic               valid;
    logic               ready;
    logic [BOOST_W-1:0] voltage_boost_mv;
    logic               iterm_update_valid;
    logic [CUR_W-1:0]   iterm_update_ma;
    logic               full_detected;
    logic               force_term_valid;
    logic [FORCE_W-1:0] force_term_ma;

    modport source (
        output valid, voltage_boost_mv, iterm_update_valid, iterm_update_ma,
               full_detected, force_term_valid, force_term_ma,
        input  ready
    );

    modport sink (
        input  valid, voltage_boost_mv, iterm_update_valid, iterm_update_ma,
               full_detected, force_term_valid, force_term_ma,
        output ready
    );
endinterface

`default_nettype wire

// File: hdl/ctfs_cfg.sv
// ----------------------------------------------------------------------------
// Sequencer configuration registers
// Holds the termination thresholds and mode enables written by software.
// ----------------------------------------------------------------------------
`default_nettype none

module ctfs_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [ctfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ctfs_pkg::CFG_DATA_W-1:0] cfg_data,
    output ctfs_pkg::cfg_t                      cfg
);
    import ctfs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_TERM_VOLTAGE:     cfg_next.term_voltage_mv = cfg_data[VOLT_W-1:0];
                CFG_TERM_CURRENT:     cfg_next.term_current_ma = cfg_data[CUR_W-1:0];
                CFG_FFC_TERM_CURRENT: cfg_next.ffc_term_current_ma = cfg_data[CUR_W-1:0];
                CFG_FORCE_TERM_EN:    cfg_next.force_term_enable = cfg_data[0];
                CFG_FFC_AFTER_DC:     cfg_next.ffc_after_dc_done_only = cfg_data[0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.term_voltage_mv        <= TERM_VOLTAGE_RST;
            cfg_reg.term_current_ma        <= TERM_CURRENT_RST;
            cfg_reg.ffc_term_current_ma    <= FFC_TERM_CURRENT_RST;
            cfg_reg.force_term_enable      <= 1'b0;
            cfg_reg.ffc_after_dc_done_only <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: hdl/ctfs_core.sv
// ----------------------------------------------------------------------------
// Sequencer step logic
// Holds the boost and full-check state and computes one result per item.
// ----------------------------------------------------------------------------
`default_nettype none

module ctfs_core #(
    parameter int FULL_CHECK_TIMES = ctfs_pkg::FULL_CHECK_TIMES_DEF,
    parameter int FFC_EXIT_TIMES   = ctfs_pkg::FFC_EXIT_TIMES_DEF,
    parameter int FFC_DELAY_TICKS  = ctfs_pkg::FFC_DELAY_TICKS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step_en,
    input  wire ctfs_pkg::cfg_t      cfg,
    input  wire ctfs_pkg::in_item_t  item,
    output ctfs_pkg::out_item_t      result
);
    import ctfs_pkg::*;

    localparam int FW = $clog2(FULL_CHECK_TIMES + 1);
    localparam int EW = $clog2(FFC_EXIT_TIMES + 1);
    localparam int DW = 2;

    logic               seen_reg, seen_next;
    logic               started_reg, started_next;
    logic               ended_reg, ended_next;
    logic [DW-1:0]      delay_reg, delay_next;
    logic [EW-1:0]      exit_reg, exit_next;
    logic [BOOST_W-1:0] last_reg, last_next;
    logic [FW-1:0]      full_reg, full_next;

    logic                     gate_open;
    logic                     in_delay;
    logic [BOOST_W-1:0]       req_eff;
    logic [EW-1:0]            exit_inc;
    logic [FW:0]              full_inc;
    logic                     full_hit;
    logic                     ended_tick;
    logic signed [CMP_W-1:0]  thr;
    logic signed [CMP_W-1:0]  vbat;
    logic signed [CMP_W-1:0]  ichg;
    logic signed [CMP_W-1:0]  iavg;
    logic signed [CMP_W-1:0]  imain;
    logic signed [CMP_W-1:0]  iaux;
    logic signed [CMP_W-1:0]  ith;
    logic                     check_run;
    logic                     allow;
    logic                     dual;
    logic                     qual;
    logic [BOOST_W-1:0]       boost;
    logic                     iv;
    logic [CUR_W-1:0]         ima;
    logic                     full;

    assign gate_open = !cfg.ffc_after_dc_done_only || item.dc_charge_done;
    assign in_delay  = cfg.ffc_after_dc_done_only && (delay_reg < DW'(FFC_DELAY_TICKS));
    assign req_eff   = in_delay ? DELAY_BOOST_MV : item.ffc_boost_request_mv;
    assign exit_inc  = exit_reg + 1'b1;
    assign full_inc  = {1'b0, full_reg} + 1'b1;
    assign full_hit  = full_inc >= (FW + 1)'(FULL_CHECK_TIMES);

    assign thr   = signed'({3'b000, cfg.term_voltage_mv})
                 - signed'({6'b000000, item.vterm_decrease_mv}) - FULL_DELTA_MV;
    assign vbat  = signed'({3'b000, item.bat_voltage_mv});
    assign ichg  = CMP_W'(item.charge_current_ma);
    assign iavg  = CMP_W'(item.charge_current_avg_ma);
    assign imain = CMP_W'(item.main_gauge_current_ma);
    assign iaux  = CMP_W'(item.aux_gauge_current_ma);

    always_comb
    begin
        seen_next    = seen_reg;
        started_next = started_reg;
        ended_next   = ended_reg;
        delay_next   = delay_reg;
        exit_next    = exit_reg;
        last_next    = last_reg;
        boost        = '0;
        iv           = 1'b0;
        ima          = '0;
        if (op_t'(item.op) == OP_TICK && seen_reg && gate_open)
        begin
            if (in_delay)
            begin
                delay_next = delay_reg + 1'b1;
            end
            if (ended_reg)
            begin
                last_next = '0;
                iv        = 1'b1;
                ima       = cfg.ffc_term_current_ma;
            end
            else if (req_eff != '0)
            begin
                exit_next    = '0;
                last_next    = req_eff;
                started_next = 1'b1;
                boost        = req_eff;
            end
            else if (started_reg)
            begin
                if (exit_inc < EW'(FFC_EXIT_TIMES))
                begin
                    exit_next = exit_inc;
                    boost     = last_reg;
                end
                else
                begin
                    ended_next = 1'b1;
                    exit_next  = '0;
                end
            end
        end
        case (op_t'(item.op))
            OP_STOP:
            begin
                started_next = 1'b0;
                ended_next   = 1'b0;
                seen_next    = 1'b0;
                delay_next   = '0;
                iv           = 1'b1;
                ima          = cfg.term_current_ma;
            end
            OP_CHECK_START:
            begin
                seen_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // The full check sees the FFC end flag as updated by this same tick.
    assign ended_tick = (op_t'(item.op) == OP_TICK) ? ended_next : ended_reg;
    assign ith   = signed'({5'b00000, ended_tick ? cfg.ffc_term_current_ma
                                                 : cfg.term_current_ma});
    assign check_run = (op_t'(item.op) == OP_TICK) && cfg.force_term_enable
                     && item.battery_present && !(vbat < thr) && item.charger_enabled;
    assign allow = (ichg > CURRENT_FLOOR_MA) && (iavg > CURRENT_FLOOR_MA);
    assign dual  = item.aux_gauge_present && (ichg <= DUAL_TOTAL_MA)
                 && ((imain < DUAL_SINGLE_MA) || (iaux < DUAL_SINGLE_MA));
    assign qual  = allow && (((ichg < ith) && (iavg < ith)) || dual);
    assign full  = check_run && qual && full_hit;

    always_comb
    begin
        full_next = full_reg;
        if (check_run)
        begin
            if (!qual)
            begin
                full_next = '0;
            end
            else if (full_hit)
            begin
                full_next = FW'(FULL_CHECK_TIMES);
            end
            else
            begin
                full_next = full_inc[FW-1:0];
            end
        end
    end

    always_comb
    begin
        result.voltage_boost_mv   = boost;
        result.iterm_update_valid = iv;
        result.iterm_update_ma    = ima;
        result.full_detected      = full;
        result.force_term_valid   = (op_t'(item.op) == OP_TICK) && cfg.force_term_enable;
        result.force_term_ma      = full ? FORCED_ITERM_MA : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg    <= 1'b0;
            started_reg <= 1'b0;
            ended_reg   <= 1'b0;
            delay_reg   <= '0;
            exit_reg    <= '0;
            last_reg    <= '0;
            full_reg    <= '0;
        end
        else if (step_en)
        begin
            seen_reg    <= seen_next;
            started_reg <= started_next;
            ended_reg   <= ended_next;
            delay_reg   <= delay_next;
            exit_reg    <= exit_next;
            last_reg    <= last_next;
            full_reg    <= full_next;
        end
    end

    a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && op_t'(item.op) == OP_STOP |=> !started_reg && !ended_reg && !seen_reg)
        else $error("stop item did not clear the FFC flags");

    a_ended_needs_started: assert property (@(posedge clk) disable iff (!rst_n)
        ended_reg |-> started_reg)
        else $error("FFC ended without having started");

    a_full_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg <= FW'(FULL_CHECK_TIMES))
        else $error("full count above its saturation value");

    a_exit_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        exit_reg < EW'(FFC_EXIT_TIMES))
        else $error("exit count reached its limit without ending FFC");

    a_boost_needs_adapter: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && result.voltage_boost_mv != '0 |-> seen_reg)
        else $error("boost granted before the adapter check started");

endmodule

`default_nettype wire

// File: hdl/charge_termination_ffc_sequencer.sv
// ----------------------------------------------------------------------------
// Charge termination and FFC boost sequencer
// Top level: configuration registers, input register, step logic and result register.
// ----------------------------------------------------------------------------
// Items arrive on in_ch, one per monitor event (tick, charging stop or
// direct-charge check start), and every item yields exactly one result item
// on out_ch. Both channels use valid/ready; an item moves on an edge where
// both are high.
// An accepted item sits in the input register, where the step logic works
// on it; the result is then registered in the result register, which drives
// out_ch.valid. One item is accepted per cycle while out_ch does not stall;
// the step logic between the two registers is combinational.
// When out_ch stalls, the result register holds its item and the input
// register still takes one more item; in_ch.ready drops only when both are
// full.
// The configuration port writes one register per edge with cfg_we high and
// is meant to be used only while no items are in flight.
// Reset clears all sequencing state and loads the register defaults; there
// is no clearing pass, and items are accepted as soon as reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module charge_termination_ffc_sequencer #(
    parameter int FULL_CHECK_TIMES = ctfs_pkg::FULL_CHECK_TIMES_DEF,
    parameter int FFC_EXIT_TIMES   = ctfs_pkg::FFC_EXIT_TIMES_DEF,
    parameter int FFC_DELAY_TICKS  = ctfs_pkg::FFC_DELAY_TICKS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [ctfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ctfs_pkg::CFG_DATA_W-1:0] cfg_data,
    ctfs_in_if.sink                              in_ch,
    ctfs_out_if.source                           out_ch
);
    import ctfs_pkg::*;

    cfg_t      cfg;
    in_item_t  in_item_reg;
    logic      in_valid_reg;
    out_item_t step_result;
    out_item_t out_item_reg;
    logic      out_valid_reg;
    logic      advance;
    logic      accept;

    assign advance     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;
    assign accept      = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg.op                    <= in_ch.op;
            in_item_reg.battery_present       <= in_ch.battery_present;
            in_item_reg.charger_enabled       <= in_ch.charger_enabled;
            in_item_reg.bat_voltage_mv        <= in_ch.bat_voltage_mv;
            in_item_reg.vterm_decrease_mv     <= in_ch.vterm_decrease_mv;
            in_item_reg.charge_current_ma     <= in_ch.charge_current_ma;
            in_item_reg.charge_current_avg_ma <= in_ch.charge_current_avg_ma;
            in_item_reg.aux_gauge_present     <= in_ch.aux_gauge_present;
            in_item_reg.main_gauge_current_ma <= in_ch.main_gauge_current_ma;
            in_item_reg.aux_gauge_current_ma  <= in_ch.aux_gauge_current_ma;
            in_item_reg.ffc_boost_request_mv  <= in_ch.ffc_boost_request_mv;
            in_item_reg.dc_charge_done        <= in_ch.dc_charge_done;
        end
        if (advance)
        begin
            out_item_reg <= step_result;
        end
    end

    ctfs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ctfs_core #(
        .FULL_CHECK_TIMES (FULL_CHECK_TIMES),
        .FFC_EXIT_TIMES   (FFC_EXIT_TIMES),
        .FFC_DELAY_TICKS  (FFC_DELAY_TICKS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .cfg     (cfg),
        .item    (in_item_reg),
        .result  (step_result)
    );

    assign out_ch.valid              = out_valid_reg;
    assign out_ch.voltage_boost_mv   = out_item_reg.voltage_boost_mv;
    assign out_ch.iterm_update_valid = out_item_reg.iterm_update_valid;
    assign out_ch.iterm_update_ma    = out_item_reg.iterm_update_ma;
    assign out_ch.full_detected      = out_item_reg.full_detected;
    assign out_ch.force_term_valid   = out_item_reg.force_term_valid;
    assign out_ch.force_term_ma      = out_item_reg.force_term_ma;

endmodule

`default_nettype wire
